FILE: sv/tlnef_pkg.sv
package tlnef_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SQUEEZE_BLANK    = 3'd0,
    CFG_NUMBER_NONBLANK  = 3'd1,
    CFG_NUMBER_ALL       = 3'd2,
    CFG_SHOW_ENDS        = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W = 3;

  // Escape prefix put ahead of the final byte
  typedef enum logic [1:0] {
    PFX_NONE,        // no prefix
    PFX_CARET,       // "^"
    PFX_META,        // "M-"
    PFX_META_CARET   // "M-^"
  } pfx_t;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_TAB_SHOWN = 8'h49;   // 'I'
  localparam logic [3:0] CH_DIGIT_HI  = 4'h3;    // upper nibble of '0'..'9'

  // Byte class bounds for meta notation
  localparam logic [7:0] META_LO     = 8'd128;
  localparam logic [7:0] META_CTL_HI = 8'd159;
  localparam logic [7:0] META_TOP    = 8'd255;
  localparam logic [7:0] CTL_END     = 8'd32;
  localparam logic [7:0] CARET_OFS   = 8'd64;

endpackage

FILE: sv/text_line_number_escape_filter.sv
// Text line-numbering and escape filter, cat-style formatting.
// Input channel in_*: one raw text byte per transaction (in_tdata).
// Output channel out_*: formatted bytes (out_tdata); out_tlast marks the last
// byte produced by one input byte. A squeezed repeated empty line produces no
// output transaction at all.
// Configuration channel cfg_*: cfg_index selects the option register
// (0 squeeze blank, 1 number non-empty, 2 number all, 3 show ends,
// 4 show tabs, 5 show nonprinting), bit cfg_data is written; other indexes
// are ignored. cfg_ready is always high; write only while the block is idle.
// An accepted input byte waits in the stage register while its output bytes
// go out one per cycle through the output register unless out_tready stalls
// it; an item has up to NUMBER_DIGITS + 5 output bytes, with a line number
// and an "M-^" escape.
// The output register and the stage register decouple the two sides: a new
// byte is taken only into an empty stage or in the same cycle the previous
// item hands over its last byte. When out_tready is low the output holds and
// the stage stops. Reset (rst_n low at a clock edge) clears all options, the
// line count and the line flags (after a newline).
module text_line_number_escape_filter #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [7:0] in_byte
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  // out_tdata: [7:0] out_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlnef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);

  localparam int CNT_W = 4 * NUMBER_DIGITS;
  localparam int LEN_W = $clog2(NUMBER_DIGITS + 7);
  localparam int POS_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  // Option registers
  logic sq_blank_r, num_nonblank_r, num_all_r, show_ends_r, show_tabs_r, show_np_r;

  // Line state
  logic             prev_nl_r, prev_nl_nxt;
  logic             sq_armed_r, sq_armed_nxt;
  logic             in_line_r, in_line_nxt;
  logic [CNT_W-1:0] line_count_r, line_count_nxt;

  // Stage register
  logic                 stg_valid_r, stg_valid_nxt;
  logic [LEN_W-1:0]     stg_idx_r, stg_idx_nxt;
  logic                 stg_num_r;
  logic                 stg_dollar_r;
  tlnef_pkg::pfx_t      stg_pfx_r;
  logic [7:0]           stg_fin_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  // Accept-side decode
  logic            fire, is_nl, squeezed, do_num;
  tlnef_pkg::pfx_t pfx_in;
  logic [7:0]      fin_in;
  logic            cnt_max;
  logic [CNT_W-1:0] cnt_inc;
  logic             carry;

  // Emit-side selection
  logic             adv, stg_last;
  logic [LEN_W-1:0] stg_len, rem;
  logic [1:0]       plen;
  logic             done;
  logic [7:0]       emit_byte;
  logic [7:0]       dig_chr [NUMBER_DIGITS];
  logic [NUMBER_DIGITS:0] hi_zero;
  logic             bcd_ok;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  // Stage moves a byte into the output register when it is empty or being read
  assign adv       = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || (adv && stg_last);
  assign fire      = in_tvalid && in_tready;

  // Classify the incoming byte and decide numbering
  always_comb begin
    is_nl    = (in_tdata == tlnef_pkg::CH_NL);
    squeezed = sq_blank_r && prev_nl_r && is_nl && sq_armed_r;
    do_num   = 1'b0;
    in_line_nxt = in_line_r;
    if (num_nonblank_r) begin
      if (!is_nl) begin
        if (!in_line_r) begin
          do_num      = 1'b1;
          in_line_nxt = 1'b1;
        end
      end else begin
        in_line_nxt = 1'b0;
      end
    end else if (num_all_r) begin
      do_num = prev_nl_r;
    end
  end

  // Saturating BCD increment of the line count
  always_comb begin
    cnt_max = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (line_count_r[4*i +: 4] != 4'd9) cnt_max = 1'b0;
    end
    carry   = 1'b1;
    cnt_inc = line_count_r;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (line_count_r[4*i +: 4] == 4'd9) begin
          cnt_inc[4*i +: 4] = 4'd0;
        end else begin
          cnt_inc[4*i +: 4] = line_count_r[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  // Pick the escape prefix and the final byte
  always_comb begin
    pfx_in = tlnef_pkg::PFX_NONE;
    fin_in = in_tdata;
    if (show_tabs_r && in_tdata == tlnef_pkg::CH_TAB) begin
      pfx_in = tlnef_pkg::PFX_CARET;
      fin_in = tlnef_pkg::CH_TAB_SHOWN;
    end else if (show_np_r) begin
      if (in_tdata >= tlnef_pkg::META_LO && in_tdata <= tlnef_pkg::META_CTL_HI) begin
        pfx_in = tlnef_pkg::PFX_META_CARET;
        fin_in = in_tdata - tlnef_pkg::CARET_OFS;
      end else if ((in_tdata < tlnef_pkg::CTL_END && in_tdata != tlnef_pkg::CH_NL &&
                    in_tdata != tlnef_pkg::CH_TAB) || in_tdata == tlnef_pkg::CH_DEL) begin
        pfx_in = tlnef_pkg::PFX_CARET;
        fin_in = (in_tdata == tlnef_pkg::CH_DEL) ? tlnef_pkg::CH_QMARK
                                                 : in_tdata + tlnef_pkg::CARET_OFS;
      end else if (in_tdata > tlnef_pkg::META_CTL_HI && in_tdata < tlnef_pkg::META_TOP) begin
        pfx_in = tlnef_pkg::PFX_META;
        fin_in = in_tdata - tlnef_pkg::META_LO;
      end else if (in_tdata == tlnef_pkg::META_TOP) begin
        pfx_in = tlnef_pkg::PFX_META_CARET;
        fin_in = tlnef_pkg::CH_QMARK;
      end
    end
  end

  // Next line state; a squeezed newline leaves everything as it is
  always_comb begin
    prev_nl_nxt    = prev_nl_r;
    sq_armed_nxt   = sq_armed_r;
    line_count_nxt = line_count_r;
    if (fire && !squeezed) begin
      prev_nl_nxt  = is_nl;
      sq_armed_nxt = prev_nl_r && is_nl;
      if (do_num && !cnt_max) line_count_nxt = cnt_inc;
    end
  end

  // Line number digits, most significant first, leading zeros as spaces.
  // The count only changes when a new item enters the stage, so the stage
  // reads it directly.
  always_comb begin
    hi_zero[NUMBER_DIGITS] = 1'b1;
    for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
      hi_zero[k] = hi_zero[k+1] && (line_count_r[4*k +: 4] == 4'd0);
    end
    for (int p = 0; p < NUMBER_DIGITS; p++) begin
      if (hi_zero[NUMBER_DIGITS-1-p] && p != NUMBER_DIGITS - 1) begin
        dig_chr[p] = tlnef_pkg::CH_SPACE;
      end else begin
        dig_chr[p] = {tlnef_pkg::CH_DIGIT_HI, line_count_r[4*(NUMBER_DIGITS-1-p) +: 4]};
      end
    end
  end

  // Length of the staged item's output run
  always_comb begin
    unique case (stg_pfx_r)
      tlnef_pkg::PFX_NONE:       plen = 2'd0;
      tlnef_pkg::PFX_CARET:      plen = 2'd1;
      tlnef_pkg::PFX_META:       plen = 2'd2;
      tlnef_pkg::PFX_META_CARET: plen = 2'd3;
      default:                   plen = 2'd0;
    endcase
    stg_len = (stg_num_r ? LEN_W'(NUMBER_DIGITS + 1) : LEN_W'(0))
            + LEN_W'(stg_dollar_r) + LEN_W'(plen) + LEN_W'(1);
    stg_last = (stg_idx_r == stg_len - LEN_W'(1));
  end

  // Select the byte at the current run position
  always_comb begin
    rem       = stg_idx_r;
    done      = 1'b0;
    emit_byte = stg_fin_r;
    if (stg_num_r) begin
      if (rem < LEN_W'(NUMBER_DIGITS)) begin
        emit_byte = dig_chr[rem[POS_W-1:0]];
        done      = 1'b1;
      end else if (rem == LEN_W'(NUMBER_DIGITS)) begin
        emit_byte = tlnef_pkg::CH_TAB;
        done      = 1'b1;
      end else begin
        rem = rem - LEN_W'(NUMBER_DIGITS + 1);
      end
    end
    if (!done && stg_dollar_r) begin
      if (rem == LEN_W'(0)) begin
        emit_byte = tlnef_pkg::CH_DOLLAR;
        done      = 1'b1;
      end else begin
        rem = rem - LEN_W'(1);
      end
    end
    if (!done && rem < LEN_W'(plen)) begin
      unique case (stg_pfx_r)
        tlnef_pkg::PFX_CARET: emit_byte = tlnef_pkg::CH_CARET;
        tlnef_pkg::PFX_META:
          emit_byte = (rem == LEN_W'(0)) ? tlnef_pkg::CH_M : tlnef_pkg::CH_DASH;
        tlnef_pkg::PFX_META_CARET:
          emit_byte = (rem == LEN_W'(0)) ? tlnef_pkg::CH_M :
                      (rem == LEN_W'(1)) ? tlnef_pkg::CH_DASH : tlnef_pkg::CH_CARET;
        default: emit_byte = stg_fin_r;
      endcase
    end
  end

  // Stage and output control
  always_comb begin
    stg_valid_nxt = stg_valid_r;
    stg_idx_nxt   = stg_idx_r;
    if (adv) begin
      if (stg_last) begin
        stg_valid_nxt = 1'b0;
      end else begin
        stg_idx_nxt = stg_idx_r + LEN_W'(1);
      end
    end
    if (fire && !squeezed) begin
      stg_valid_nxt = 1'b1;
      stg_idx_nxt   = '0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_blank_r     <= 1'b0;
      num_nonblank_r <= 1'b0;
      num_all_r      <= 1'b0;
      show_ends_r    <= 1'b0;
      show_tabs_r    <= 1'b0;
      show_np_r      <= 1'b0;
      prev_nl_r      <= 1'b1;
      sq_armed_r     <= 1'b0;
      in_line_r      <= 1'b0;
      line_count_r   <= '0;
      stg_valid_r    <= 1'b0;
      stg_idx_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tlnef_pkg::CFG_SQUEEZE_BLANK:    sq_blank_r     <= cfg_data;
          tlnef_pkg::CFG_NUMBER_NONBLANK:  num_nonblank_r <= cfg_data;
          tlnef_pkg::CFG_NUMBER_ALL:       num_all_r      <= cfg_data;
          tlnef_pkg::CFG_SHOW_ENDS:        show_ends_r    <= cfg_data;
          tlnef_pkg::CFG_SHOW_TABS:        show_tabs_r    <= cfg_data;
          tlnef_pkg::CFG_SHOW_NONPRINTING: show_np_r      <= cfg_data;
          default: ;
        endcase
      end
      prev_nl_r    <= prev_nl_nxt;
      sq_armed_r   <= sq_armed_nxt;
      if (fire && !squeezed) in_line_r <= in_line_nxt;
      line_count_r <= line_count_nxt;
      stg_valid_r  <= stg_valid_nxt;
      stg_idx_r    <= stg_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (fire && !squeezed) begin
      stg_num_r    <= do_num;
      stg_dollar_r <= show_ends_r && is_nl;
      stg_pfx_r    <= pfx_in;
      stg_fin_r    <= fin_in;
    end
    if (adv) begin
      out_byte_r <= emit_byte;
      out_last_r <= stg_last;
    end
  end

  // Every count digit stays a decimal digit
  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (line_count_r[4*i +: 4] > 4'd9) bcd_ok = 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r |-> (stg_idx_r < stg_len))
    else $error("stage position beyond its run");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && stg_valid_r) |-> (adv && stg_last))
    else $error("input taken while stage still holds bytes");

  a_bcd_count: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_ok)
    else $error("line count holds a non-decimal digit");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stg_last && !fire) |=> !stg_valid_r)
    else $error("stage not emptied after its last byte");

  a_nl_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_nl) |=> prev_nl_r)
    else $error("newline not recorded");
`endif

endmodule

FILE: sim/text_line_number_escape_filter_tb.sv
`timescale 1ns / 100ps

module text_line_number_escape_filter_tb;

  localparam int NUM_DIGITS      = 6;
  localparam int COUNT_MAX       = 999_999;
  localparam int CLK_HALF_NS     = 6;
  localparam int TIMEOUT_CYCLES  = 600_000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int MAX_REPORTS     = 10;
  localparam int IDX_W           = tlnef_pkg::CFG_IDX_W;

  // Indexes past the last option register; the block must ignore them
  localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             data;
  } opt_write_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;
  logic             out_tlast;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index  = '0;
  logic             cfg_data   = 1'b0;

  // Shadow copy of the option registers and the line state
  bit [5:0] opt_reg       = '0;
  bit       after_newline = 1'b1;
  bit       blank_printed = 1'b0;
  bit       line_open     = 1'b0;
  int       line_count    = 0;

  logic [7:0] pending_bytes[$];
  opt_write_t opt_writes[$];
  out_beat_t  expected_beats[$];

  int bytes_sent       = 0;
  int beats_checked    = 0;
  int squeezed_lines   = 0;
  int settings_applied = 0;
  int error_count      = 0;
  int tx_idle_pct      = 38;
  int rx_idle_pct      = 88;

  text_line_number_escape_filter #(
    .NUMBER_DIGITS(NUM_DIGITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  function automatic void push_beat(input logic [7:0] b, input logic last);
    expected_beats.push_back('{data: b, last: last});
  endfunction

  // Advance the line count (saturating) and queue the right-aligned number plus tab
  function automatic void push_line_number();
    int         v;
    logic [7:0] digit_chars[NUM_DIGITS];
    if (line_count < COUNT_MAX) line_count++;
    v = line_count;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (v == 0 && i != NUM_DIGITS - 1) digit_chars[i] = tlnef_pkg::CH_SPACE;
      else digit_chars[i] = {tlnef_pkg::CH_DIGIT_HI, 4'(v % 10)};
      v = v / 10;
    end
    foreach (digit_chars[i]) push_beat(digit_chars[i], 1'b0);
    push_beat(tlnef_pkg::CH_TAB, 1'b0);
  endfunction

  // Queue the formatted bytes that one raw input byte produces
  function automatic void predict_formatted(input logic [7:0] raw);
    logic [7:0] c;
    bit         nl;
    c  = raw;
    nl = (raw == tlnef_pkg::CH_NL);

    // Drop a repeated empty line entirely
    if (opt_reg[tlnef_pkg::CFG_SQUEEZE_BLANK]) begin
      if (after_newline && nl && blank_printed) begin
        squeezed_lines++;
        return;
      end
      blank_printed = 1'b0;
    end

    if (opt_reg[tlnef_pkg::CFG_NUMBER_NONBLANK]) begin
      if (!nl) begin
        if (!line_open) begin
          push_line_number();
          line_open = 1'b1;
        end
      end else begin
        line_open = 1'b0;
      end
    end else if (opt_reg[tlnef_pkg::CFG_NUMBER_ALL] && after_newline) begin
      push_line_number();
    end

    if (opt_reg[tlnef_pkg::CFG_SHOW_ENDS] && nl) push_beat(tlnef_pkg::CH_DOLLAR, 1'b0);

    if (opt_reg[tlnef_pkg::CFG_SHOW_TABS] && c == tlnef_pkg::CH_TAB) begin
      push_beat(tlnef_pkg::CH_CARET, 1'b0);
      c = tlnef_pkg::CH_TAB_SHOWN;
    end

    // Caret and meta escapes; a shown tab is already 'I' and passes here
    if (opt_reg[tlnef_pkg::CFG_SHOW_NONPRINTING]) begin
      if (c >= tlnef_pkg::META_LO && c <= tlnef_pkg::META_CTL_HI) begin
        push_beat(tlnef_pkg::CH_M, 1'b0);
        push_beat(tlnef_pkg::CH_DASH, 1'b0);
        push_beat(tlnef_pkg::CH_CARET, 1'b0);
        c = c - tlnef_pkg::META_LO + tlnef_pkg::CARET_OFS;
      end else if ((c < tlnef_pkg::CTL_END && c != tlnef_pkg::CH_NL &&
                    c != tlnef_pkg::CH_TAB) || c == tlnef_pkg::CH_DEL) begin
        push_beat(tlnef_pkg::CH_CARET, 1'b0);
        c = (c == tlnef_pkg::CH_DEL) ? tlnef_pkg::CH_QMARK : c + tlnef_pkg::CARET_OFS;
      end else if (c > tlnef_pkg::META_CTL_HI && c < tlnef_pkg::META_TOP) begin
        push_beat(tlnef_pkg::CH_M, 1'b0);
        push_beat(tlnef_pkg::CH_DASH, 1'b0);
        c = c - tlnef_pkg::META_LO;
      end else if (c == tlnef_pkg::META_TOP) begin
        push_beat(tlnef_pkg::CH_M, 1'b0);
        push_beat(tlnef_pkg::CH_DASH, 1'b0);
        push_beat(tlnef_pkg::CH_CARET, 1'b0);
        c = tlnef_pkg::CH_QMARK;
      end
    end

    push_beat(c, 1'b1);
    blank_printed = after_newline && nl;
    after_newline = nl;
  endfunction

  // Weighted pick of a text byte: half printable, with tabs, controls and high bytes
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 8'($urandom_range(tlnef_pkg::CH_DEL - 1, tlnef_pkg::CH_SPACE));
    if (r < 60) return tlnef_pkg::CH_TAB;
    if (r < 72) return 8'($urandom_range(tlnef_pkg::CTL_END - 1, 0));
    if (r < 84) return 8'($urandom_range(tlnef_pkg::META_CTL_HI, tlnef_pkg::META_LO));
    if (r < 96)
      return 8'($urandom_range(tlnef_pkg::META_TOP - 1, tlnef_pkg::META_CTL_HI + 1));
    if (r < 98) return tlnef_pkg::CH_DEL;
    return tlnef_pkg::META_TOP;
  endfunction

  // Input driver: predict on each accepted transaction, then present the next byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_formatted(in_tdata);
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Option write driver: mirror each accepted write into the shadow registers
  always @(posedge clk) begin : opt_driver
    opt_write_t w;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= tlnef_pkg::CFG_SHOW_NONPRINTING)
        opt_reg[cfg_index] = cfg_data;
      if (!cfg_valid || cfg_ready) begin
        if (opt_writes.size() != 0) begin
          w = opt_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.idx;
          cfg_data  <= w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each accepted transaction with the oldest expected byte
  always @(posedge clk) begin : out_monitor
    out_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected output byte 0x%02h last=%0b",
                     $realtime, out_tdata, out_tlast);
        end else begin
          want = expected_beats.pop_front();
          beats_checked++;
          if (out_tdata !== want.data || out_tlast !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: mismatch: expected byte 0x%02h last=%0b, got 0x%02h last=%0b",
                       $realtime, want.data, want.last, out_tdata, out_tlast);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #(2 * CLK_HALF_NS * TIMEOUT_CYCLES);
    $display("Timeout with %0d output bytes still expected", expected_beats.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Hold until every queued byte is accepted and every expected byte has arrived
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_tvalid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_options(input bit [5:0] opts);
    for (int i = 0; i <= int'(tlnef_pkg::CFG_SHOW_NONPRINTING); i++)
      opt_writes.push_back('{idx: IDX_W'(i), data: opts[i]});
    while (opt_writes.size() != 0 || cfg_valid) @(posedge clk);
    settings_applied++;
  endtask

  initial begin
    bit [5:0] opts;
    int       pick;
    int       run_len;

    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain pass-through of the byte extremes with every option off
    apply_options(6'b000000);
    pending_bytes = '{8'h00, 8'hFF, 8'h61, tlnef_pkg::CH_NL};
    wait_drained();

    // Everything but non-empty numbering: escapes of every class, squeezed blank lines
    apply_options(6'b111101);
    pending_bytes = '{tlnef_pkg::CH_TAB, 8'h01, tlnef_pkg::CH_DEL, tlnef_pkg::META_LO,
                      tlnef_pkg::META_CTL_HI, 8'hA0, 8'hFE, tlnef_pkg::META_TOP,
                      tlnef_pkg::CH_NL, tlnef_pkg::CH_NL, tlnef_pkg::CH_NL, 8'h78,
                      tlnef_pkg::CH_NL};
    wait_drained();

    // Non-empty numbering overriding number-all; tab passes with only escapes on.
    // Writes to the spare indexes must not disturb anything.
    opt_writes.push_back('{idx: CFG_SPARE_A, data: 1'b1});
    opt_writes.push_back('{idx: CFG_SPARE_B, data: 1'b1});
    apply_options(6'b100110);
    pending_bytes = '{tlnef_pkg::CH_TAB, 8'h1F, tlnef_pkg::CH_NL, tlnef_pkg::CH_NL, 8'h7A,
                      tlnef_pkg::CH_SPACE, 8'h7E, tlnef_pkg::CH_NL};
    wait_drained();

    // Random text in phases; each phase applies an option setting and an idle pattern
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 3) begin
        tx_idle_pct = 38;
        rx_idle_pct = 88;
      end else if (p < 6) begin
        tx_idle_pct = 88;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 0) opts = '0;
      else if (p == 1) opts = '1;
      else opts = 6'($urandom_range(63));
      apply_options(opts);

      while (pending_bytes.size() < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          run_len = $urandom_range(4, 1);
          repeat (run_len) pending_bytes.push_back(tlnef_pkg::CH_NL);
        end else if (pick < 25) begin
          run_len = $urandom_range(6, 1);
          repeat (run_len) pending_bytes.push_back(8'($urandom_range(255)));
        end else begin
          run_len = $urandom_range(12, 0);
          repeat (run_len) pending_bytes.push_back(pick_text_byte());
          pending_bytes.push_back(tlnef_pkg::CH_NL);
        end
      end
      wait_drained();
    end

    $display("Sent %0d input bytes under %0d option settings; %0d blank lines squeezed",
             bytes_sent, settings_applied, squeezed_lines);
    $display("Checked %0d output bytes, %0d errors", beats_checked, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tlnef_pkg.sv
sv/text_line_number_escape_filter.sv
sim/text_line_number_escape_filter_tb.sv
